>>> rtl/c8x_pkg.sv
// Shared types and constants for the CHIP-8 instruction execute block.
package c8x_pkg;

   // Call stack geometry
   localparam int STACK_DEPTH = 16;
   localparam int SP_W        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   // Program counter reset value (0x200, start of program space)
   localparam logic [11:0] RESET_PC = 12'h200;

   // Index of the flag register VF
   localparam logic [3:0] VF_IDX = 4'hF;

   // Return-from-subroutine word
   localparam logic [15:0] INSTR_RET = 16'h00EE;

   // Top opcode nibble
   typedef enum logic [3:0] {
      OP_SYS    = 4'h0,
      OP_JP     = 4'h1,
      OP_CALL   = 4'h2,
      OP_SE_K   = 4'h3,
      OP_SNE_K  = 4'h4,
      OP_SE_V   = 4'h5,
      OP_LD_K   = 4'h6,
      OP_ADD_K  = 4'h7,
      OP_ALU    = 4'h8,
      OP_SNE_V  = 4'h9,
      OP_LD_I   = 4'hA,
      OP_JP_V0  = 4'hB,
      OP_RND    = 4'hC,
      OP_DRW    = 4'hD,
      OP_SKP    = 4'hE,
      OP_MISC   = 4'hF
   } op_type;

   // 8xyN subcodes
   typedef enum logic [3:0] {
      ALU_LD   = 4'h0,
      ALU_OR   = 4'h1,
      ALU_AND  = 4'h2,
      ALU_XOR  = 4'h3,
      ALU_ADD  = 4'h4,
      ALU_SUB  = 4'h5,
      ALU_SHR  = 4'h6,
      ALU_SUBN = 4'h7,
      ALU_SHL  = 4'hE
   } alu_type;

   // FxKK low-byte codes
   localparam logic [7:0] FX_GET_DT = 8'h07;
   localparam logic [7:0] FX_SET_DT = 8'h15;
   localparam logic [7:0] FX_SET_ST = 8'h18;
   localparam logic [7:0] FX_ADD_I  = 8'h1E;

   // V register write request: Vx write plus optional VF flag update
   typedef struct packed {
      logic       wr_en;
      logic [3:0] wr_reg;
      logic [7:0] wr_value;
      logic       flag_en;
      logic       flag;
   } vwrite_type;

   // Everything one instruction decides
   typedef struct packed {
      logic [11:0] next_pc;
      logic [15:0] index_value;
      vwrite_type  vw;
      logic [7:0]  delay_value;
      logic [7:0]  sound_value;
      logic        push;
      logic        pop;
      logic        unsupported;
   } exec_type;

endpackage

>>> rtl/c8x_regfile.sv
// V register file: 16 x 8 memory with registered reads, bypass, valid bits, VF and V0 copies.
module c8x_regfile (
   input  logic               clock,
   input  logic               reset,
   input  c8x_pkg::vwrite_type vw,
   input  logic [3:0]         ra_x,
   input  logic [3:0]         ra_y,
   output logic [7:0]         vx,
   output logic [7:0]         vy,
   output logic [7:0]         v0
);

   logic [7:0]  mem [16];
   logic [15:0] vld_ff, vld_in;
   logic [7:0]  vf_ff, vf_in;
   logic [7:0]  v0_ff, v0_in;
   logic        mem_we;
   logic [7:0]  mem_x_ff, mem_y_ff;
   logic        use_mem_x_ff, use_mem_x_in;
   logic        use_mem_y_ff, use_mem_y_in;
   logic [7:0]  byp_x_ff, byp_x_in;
   logic [7:0]  byp_y_ff, byp_y_in;
   logic        hit_x, hit_y;

   // VF lives outside the memory so a flag op can write Vx and VF together
   assign mem_we = vw.wr_en && (vw.wr_reg != c8x_pkg::VF_IDX);

   always_comb begin
      if (vw.wr_en && (vw.wr_reg == c8x_pkg::VF_IDX)) begin
         vf_in = vw.wr_value;
      end else if (vw.flag_en) begin
         vf_in = {7'b0, vw.flag};
      end else begin
         vf_in = vf_ff;
      end
   end

   assign vld_in = vld_ff | (mem_we ? (16'b1 << vw.wr_reg) : 16'b0);
   assign v0_in  = (mem_we && (vw.wr_reg == 4'h0)) ? vw.wr_value : v0_ff;

   // Read-side bypass for a write in the same cycle
   assign hit_x = mem_we && (vw.wr_reg == ra_x);
   assign hit_y = mem_we && (vw.wr_reg == ra_y);

   assign use_mem_x_in = (ra_x != c8x_pkg::VF_IDX) && !hit_x && vld_ff[ra_x];
   assign use_mem_y_in = (ra_y != c8x_pkg::VF_IDX) && !hit_y && vld_ff[ra_y];
   assign byp_x_in = (ra_x == c8x_pkg::VF_IDX) ? vf_in : (hit_x ? vw.wr_value : 8'h00);
   assign byp_y_in = (ra_y == c8x_pkg::VF_IDX) ? vf_in : (hit_y ? vw.wr_value : 8'h00);

   // Memory array
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[vw.wr_reg] <= vw.wr_value;
      end
      mem_x_ff <= mem[ra_x];
      mem_y_ff <= mem[ra_y];
   end

   // Control and flag state
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         vf_ff        <= '0;
         v0_ff        <= '0;
         use_mem_x_ff <= 1'b0;
         use_mem_y_ff <= 1'b0;
      end else begin
         vld_ff       <= vld_in;
         vf_ff        <= vf_in;
         v0_ff        <= v0_in;
         use_mem_x_ff <= use_mem_x_in;
         use_mem_y_ff <= use_mem_y_in;
      end
   end

   always_ff @(posedge clock) begin
      byp_x_ff <= byp_x_in;
      byp_y_ff <= byp_y_in;
   end

   assign vx = use_mem_x_ff ? mem_x_ff : byp_x_ff;
   assign vy = use_mem_y_ff ? mem_y_ff : byp_y_ff;
   assign v0 = v0_ff;

endmodule

>>> rtl/c8x_stack.sv
// Call stack: memory of return addresses with a wrapping stack pointer and registered top read.
module c8x_stack (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        pop,
   input  logic [11:0] push_pc,
   output logic [11:0] top_pc
);

   logic [11:0]              mem [c8x_pkg::STACK_DEPTH];
   logic [c8x_pkg::SP_W-1:0] sp_ff, sp_in, sp_inc, sp_dec;
   logic [11:0]              rd_ff;
   logic                     hit_ff;
   logic [11:0]              byp_ff;

   // Pointer wraps modulo the stack depth
   assign sp_inc = (sp_ff == c8x_pkg::SP_W'(c8x_pkg::STACK_DEPTH - 1)) ?
                   '0 : sp_ff + c8x_pkg::SP_W'(1);
   assign sp_dec = (sp_ff == '0) ?
                   c8x_pkg::SP_W'(c8x_pkg::STACK_DEPTH - 1) : sp_ff - c8x_pkg::SP_W'(1);

   always_comb begin
      if (reset) begin
         sp_in = '0;
      end else if (push) begin
         sp_in = sp_inc;
      end else if (pop) begin
         sp_in = sp_dec;
      end else begin
         sp_in = sp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
      end else begin
         sp_ff <= sp_in;
      end
   end

   // Memory: push writes the new top, read tracks the next top every cycle
   always_ff @(posedge clock) begin
      if (push) begin
         mem[sp_inc] <= push_pc;
      end
      rd_ff  <= mem[sp_in];
      hit_ff <= push;
      byp_ff <= push_pc;
   end

   assign top_pc = hit_ff ? byp_ff : rd_ff;

endmodule

>>> rtl/c8x_exec.sv
// Instruction decode and execute: next PC, I, timers, V write and stack action for one word.
module c8x_exec (
   input  logic [15:0]        instruction,
   input  logic [7:0]         random_byte,
   input  logic [7:0]         vx,
   input  logic [7:0]         vy,
   input  logic [7:0]         v0,
   input  logic [11:0]        pc,
   input  logic [15:0]        index_reg,
   input  logic [7:0]         delay_timer,
   input  logic [7:0]         sound_timer,
   input  logic [11:0]        stack_top,
   output c8x_pkg::exec_type  ex
);

   logic [3:0]  x;
   logic [3:0]  n;
   logic [7:0]  kk;
   logic [11:0] nnn;
   logic [11:0] pc_plus2;
   logic [11:0] pc_plus4;
   logic [8:0]  sum9;
   logic [7:0]  alu_res;
   logic        alu_flag_en;
   logic        alu_flag;
   logic        alu_bad;

   assign x        = instruction[11:8];
   assign n        = instruction[3:0];
   assign kk       = instruction[7:0];
   assign nnn      = instruction[11:0];
   assign pc_plus2 = pc + 12'd2;
   assign pc_plus4 = pc + 12'd4;
   assign sum9     = {1'b0, vx} + {1'b0, vy};

   // 8xyN arithmetic and logic
   always_comb begin
      alu_res     = 8'h00;
      alu_flag_en = 1'b0;
      alu_flag    = 1'b0;
      alu_bad     = 1'b0;
      case (c8x_pkg::alu_type'(n))
         c8x_pkg::ALU_LD:  alu_res = vy;
         c8x_pkg::ALU_OR:  alu_res = vx | vy;
         c8x_pkg::ALU_AND: alu_res = vx & vy;
         c8x_pkg::ALU_XOR: alu_res = vx ^ vy;
         c8x_pkg::ALU_ADD: begin
            alu_res     = sum9[7:0];
            alu_flag_en = 1'b1;
            alu_flag    = sum9[8];
         end
         c8x_pkg::ALU_SUB: begin
            alu_res     = vx - vy;
            alu_flag_en = 1'b1;
            alu_flag    = (vx >= vy);
         end
         c8x_pkg::ALU_SHR: begin
            alu_res     = {1'b0, vx[7:1]};
            alu_flag_en = 1'b1;
            alu_flag    = vx[0];
         end
         c8x_pkg::ALU_SUBN: begin
            alu_res     = vy - vx;
            alu_flag_en = 1'b1;
            alu_flag    = (vy >= vx);
         end
         c8x_pkg::ALU_SHL: begin
            alu_res     = {vx[6:0], 1'b0};
            alu_flag_en = 1'b1;
            alu_flag    = vx[7];
         end
         default: alu_bad = 1'b1;
      endcase
   end

   // Main decode
   always_comb begin
      ex             = '0;
      ex.next_pc     = pc_plus2;
      ex.index_value = index_reg;
      ex.delay_value = delay_timer;
      ex.sound_value = sound_timer;
      case (c8x_pkg::op_type'(instruction[15:12]))
         c8x_pkg::OP_SYS: begin
            if (instruction == c8x_pkg::INSTR_RET) begin
               ex.next_pc = stack_top;
               ex.pop     = 1'b1;
            end else begin
               ex.unsupported = 1'b1;
            end
         end
         c8x_pkg::OP_JP: ex.next_pc = nnn;
         c8x_pkg::OP_CALL: begin
            ex.push    = 1'b1;
            ex.next_pc = nnn;
         end
         c8x_pkg::OP_SE_K: begin
            if (vx == kk) ex.next_pc = pc_plus4;
         end
         c8x_pkg::OP_SNE_K: begin
            if (vx != kk) ex.next_pc = pc_plus4;
         end
         c8x_pkg::OP_SE_V: begin
            if (n != 4'h0) begin
               ex.unsupported = 1'b1;
            end else if (vx == vy) begin
               ex.next_pc = pc_plus4;
            end
         end
         c8x_pkg::OP_LD_K: begin
            ex.vw.wr_en    = 1'b1;
            ex.vw.wr_reg   = x;
            ex.vw.wr_value = kk;
         end
         c8x_pkg::OP_ADD_K: begin
            ex.vw.wr_en    = 1'b1;
            ex.vw.wr_reg   = x;
            ex.vw.wr_value = vx + kk;
         end
         c8x_pkg::OP_ALU: begin
            if (alu_bad) begin
               ex.unsupported = 1'b1;
            end else begin
               ex.vw.wr_en   = 1'b1;
               ex.vw.wr_reg  = x;
               ex.vw.flag_en = alu_flag_en;
               ex.vw.flag    = alu_flag;
               // With x = F the flag lands last and is what VF keeps
               ex.vw.wr_value = (alu_flag_en && (x == c8x_pkg::VF_IDX)) ?
                                {7'b0, alu_flag} : alu_res;
            end
         end
         c8x_pkg::OP_SNE_V: begin
            if (n != 4'h0) begin
               ex.unsupported = 1'b1;
            end else if (vx != vy) begin
               ex.next_pc = pc_plus4;
            end
         end
         c8x_pkg::OP_LD_I:  ex.index_value = {4'h0, nnn};
         c8x_pkg::OP_JP_V0: ex.next_pc = nnn + {4'h0, v0};
         c8x_pkg::OP_RND: begin
            ex.vw.wr_en    = 1'b1;
            ex.vw.wr_reg   = x;
            ex.vw.wr_value = random_byte & kk;
         end
         c8x_pkg::OP_MISC: begin
            case (kk)
               c8x_pkg::FX_GET_DT: begin
                  ex.vw.wr_en    = 1'b1;
                  ex.vw.wr_reg   = x;
                  ex.vw.wr_value = delay_timer;
               end
               c8x_pkg::FX_SET_DT: ex.delay_value = vx;
               c8x_pkg::FX_SET_ST: ex.sound_value = vx;
               c8x_pkg::FX_ADD_I:  ex.index_value = index_reg + {8'h00, vx};
               default:            ex.unsupported = 1'b1;
            endcase
         end
         default: ex.unsupported = 1'b1;
      endcase
   end

endmodule

>>> rtl/chip8_instruction_execute_top.sv
// CHIP-8 instruction execute unit: input register, execute stage, result register.
//
// Usage:
//   req channel carries one item per instruction: the 16-bit instruction word and
//   a random byte used by Cxkk. rsp channel returns one item per instruction with
//   the PC, I and timers after execution, the V register write and an
//   unsupported-opcode flag. csr channel writes the start address register; it is
//   always ready and should be written only while the block is idle.
// Timing:
//   An accepted item is executed as it moves from the input register into the
//   result register. One item per cycle is sustained while rsp_tready is high;
//   the limit is the single execute stage, where architectural state is read
//   and updated in the same cycle so back-to-back dependent items need no stall.
// Reset:
//   Synchronous, active high. Clears V registers, I, timers and stack pointer,
//   loads PC with 0x200 and empties both pipeline registers. Call stack entries
//   hold no value until a call writes them.
// Back-pressure:
//   With rsp_tready low the result register holds and one more item can wait in
//   the input register; req_tready drops only when both are full.
module chip8_instruction_execute_top (
   input  logic        clock,
   input  logic        reset,
   // Instruction items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [15:0] instruction, [23:16] random_byte
   // Result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [11:0] next_pc, [27:12] index_value,
                                    // [31:28] write_reg, [39:32] write_value,
                                    // [47:40] delay_value, [55:48] sound_value
   output logic [1:0]  rsp_tuser,   // [0] write_valid, [1] unsupported
   // Start address register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [11:0] csr_data
);

   // Input register
   logic        in_valid_ff, in_valid_in;
   logic [15:0] inst_ff, inst_in;
   logic [7:0]  rnd_ff, rnd_in;

   // Result register
   logic        out_valid_ff, out_valid_in;
   logic [55:0] out_data_ff, out_data_in;
   logic [1:0]  out_user_ff, out_user_in;

   // Architectural state
   logic [11:0] pc_ff, pc_in;
   logic [15:0] index_ff, index_in;
   logic [7:0]  delay_ff, delay_in;
   logic [7:0]  sound_ff, sound_in;
   logic [11:0] start_addr_ff, start_addr_in;

   logic                advance;
   logic                accept;
   logic                fire;
   logic [7:0]          vx, vy, v0;
   logic [11:0]         stack_top;
   c8x_pkg::exec_type   ex;
   c8x_pkg::vwrite_type vw_gated;
   logic                wr_valid;
   logic [3:0]          wr_reg_out;
   logic [7:0]          wr_value_out;

   // Handshake
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;
   assign fire       = in_valid_ff && advance && !reset;
   assign csr_ready  = 1'b1;

   assign in_valid_in = accept || (in_valid_ff && !fire);
   assign inst_in     = accept ? req_tdata[15:0]  : inst_ff;
   assign rnd_in      = accept ? req_tdata[23:16] : rnd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      inst_ff <= inst_in;
      rnd_ff  <= rnd_in;
   end

   // Register file, read ahead with the next instruction's fields
   assign vw_gated = fire ? ex.vw : '0;

   c8x_regfile u_regfile (
      .clock (clock),
      .reset (reset),
      .vw    (vw_gated),
      .ra_x  (inst_in[11:8]),
      .ra_y  (inst_in[7:4]),
      .vx    (vx),
      .vy    (vy),
      .v0    (v0)
   );

   c8x_stack u_stack (
      .clock   (clock),
      .reset   (reset),
      .push    (fire && ex.push),
      .pop     (fire && ex.pop),
      .push_pc (pc_ff + 12'd2),
      .top_pc  (stack_top)
   );

   c8x_exec u_exec (
      .instruction (inst_ff),
      .random_byte (rnd_ff),
      .vx          (vx),
      .vy          (vy),
      .v0          (v0),
      .pc          (pc_ff),
      .index_reg   (index_ff),
      .delay_timer (delay_ff),
      .sound_timer (sound_ff),
      .stack_top   (stack_top),
      .ex          (ex)
   );

   // State update on execute
   assign pc_in         = fire ? ex.next_pc     : pc_ff;
   assign index_in      = fire ? ex.index_value : index_ff;
   assign delay_in      = fire ? ex.delay_value : delay_ff;
   assign sound_in      = fire ? ex.sound_value : sound_ff;
   assign start_addr_in = (csr_valid && csr_ready) ? csr_data : start_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff         <= c8x_pkg::RESET_PC;
         index_ff      <= '0;
         delay_ff      <= '0;
         sound_ff      <= '0;
         start_addr_ff <= c8x_pkg::RESET_PC;
      end else begin
         pc_ff         <= pc_in;
         index_ff      <= index_in;
         delay_ff      <= delay_in;
         sound_ff      <= sound_in;
         start_addr_ff <= start_addr_in;
      end
   end

   // Result item packing
   assign wr_valid     = ex.vw.wr_en;
   assign wr_reg_out   = wr_valid ? ex.vw.wr_reg   : 4'h0;
   assign wr_value_out = wr_valid ? ex.vw.wr_value : 8'h00;

   assign out_valid_in = fire || (out_valid_ff && !rsp_tready);
   assign out_data_in  = fire ? {ex.sound_value, ex.delay_value, wr_value_out, wr_reg_out,
                                 ex.index_value, ex.next_pc} : out_data_ff;
   assign out_user_in  = fire ? {ex.unsupported, wr_valid} : out_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      out_user_ff <= out_user_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

`ifndef NO_ASSERTIONS
   // An executed item always shows up in the result register
   a_fire_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_tvalid)
      else $error("executed item did not reach the result register");

   // An unsupported opcode never writes a V register
   a_unsup_nowrite: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> !rsp_tuser[0])
      else $error("unsupported opcode reported a register write");

   // Write index and value read zero when no write happened
   a_nowrite_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> (rsp_tdata[39:28] == 12'h000))
      else $error("write fields nonzero without a write");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");
`endif

endmodule
